@@ hw/rtl/eu8_pkg.sv @@
package eu8_pkg;

  localparam int BYTE_W  = 8;
  localparam int AVAIL_W = 3;
  localparam int CP_W    = 32;
  localparam int LEN_W   = 3;
  localparam int RAW_W   = 31;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [1:0] REG_MAX_CP   = 2'd0;
  localparam logic [1:0] REG_TRAP_LO  = 2'd1;
  localparam logic [1:0] REG_TRAP_HI  = 2'd2;
  localparam logic [1:0] REG_SENTINEL = 2'd3;

  localparam logic [CP_W-1:0] MAX_CP_RESET   = 32'h7FFF_FFFF;
  localparam logic [CP_W-1:0] TRAP_LO_RESET  = 32'h0000_D800;
  localparam logic [CP_W-1:0] TRAP_HI_RESET  = 32'h0000_DFFF;
  localparam logic [CP_W-1:0] SENTINEL_RESET = 32'hFFFF_FFFF;

  localparam logic [BYTE_W-1:0] MASK_E0 = 8'hE0;
  localparam logic [BYTE_W-1:0] MASK_F0 = 8'hF0;
  localparam logic [BYTE_W-1:0] MASK_F8 = 8'hF8;
  localparam logic [BYTE_W-1:0] MASK_FC = 8'hFC;
  localparam logic [BYTE_W-1:0] MASK_FE = 8'hFE;
  localparam logic [BYTE_W-1:0] LEAD_2  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD_3  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_4  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD_5  = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD_6  = 8'hFC;
  localparam logic [BYTE_W-1:0] ASCII_TOP = 8'h80;

  localparam logic [CP_W-1:0] LIMIT_1 = 32'h0000_007F;
  localparam logic [CP_W-1:0] LIMIT_2 = 32'h0000_07FF;
  localparam logic [CP_W-1:0] LIMIT_3 = 32'h0000_FFFF;
  localparam logic [CP_W-1:0] LIMIT_4 = 32'h0010_FFFF;
  localparam logic [CP_W-1:0] LIMIT_5 = 32'h03FF_FFFF;

  localparam logic [AVAIL_W-1:0] AVAIL_MAX = 3'd6;

  typedef struct packed {
    logic             ok;
    logic [LEN_W-1:0] len;
    logic [RAW_W-1:0] cp;
  } dec_t;

  function automatic logic [LEN_W-1:0] shortest_len(input logic [CP_W-1:0] cp);
    logic [LEN_W-1:0] n;
    if (cp <= LIMIT_1) n = 3'd1;
    else if (cp <= LIMIT_2) n = 3'd2;
    else if (cp <= LIMIT_3) n = 3'd3;
    else if (cp <= LIMIT_4) n = 3'd4;
    else if (cp <= LIMIT_5) n = 3'd5;
    else n = 3'd6;
    return n;
  endfunction

endpackage

@@ hw/rtl/eu8_in_if.sv @@
interface eu8_in_if;
  import eu8_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  lead_byte;
  logic [BYTE_W-1:0]  cont_byte_1;
  logic [BYTE_W-1:0]  cont_byte_2;
  logic [BYTE_W-1:0]  cont_byte_3;
  logic [BYTE_W-1:0]  cont_byte_4;
  logic [BYTE_W-1:0]  cont_byte_5;
  logic [AVAIL_W-1:0] bytes_available;

  modport source (
    output valid, lead_byte, cont_byte_1, cont_byte_2, cont_byte_3, cont_byte_4,
           cont_byte_5, bytes_available,
    input  ready
  );

  modport sink (
    input  valid, lead_byte, cont_byte_1, cont_byte_2, cont_byte_3, cont_byte_4,
           cont_byte_5, bytes_available,
    output ready
  );
endinterface

@@ hw/rtl/eu8_out_if.sv @@
interface eu8_out_if;
  import eu8_pkg::*;

  logic             valid;
  logic             ready;
  logic [CP_W-1:0]  codepoint;
  logic [LEN_W-1:0] consumed;

  modport source (output valid, codepoint, consumed, input ready);
  modport sink (input valid, codepoint, consumed, output ready);
endinterface

@@ hw/rtl/eu8_decode.sv @@
module eu8_decode (
  input  logic [5:0][eu8_pkg::BYTE_W-1:0] bytes,
  input  logic [eu8_pkg::AVAIL_W-1:0]     avail,
  output eu8_pkg::dec_t                   dec
);
  import eu8_pkg::*;

  logic [BYTE_W-1:0]  b0;
  logic [AVAIL_W-1:0] avail_sat;
  logic [LEN_W-1:0]   len;
  logic               lead_ok;
  logic [5:0]         cont_ok;
  logic [5:0]         need;
  logic [5:0][5:0]    pl;

  assign b0 = bytes[0];

  // lead byte sets the length
  always_comb begin
    lead_ok = 1'b1;
    priority if (b0 < ASCII_TOP) len = 3'd1;
    else if ((b0 & MASK_E0) == LEAD_2) len = 3'd2;
    else if ((b0 & MASK_F0) == LEAD_3) len = 3'd3;
    else if ((b0 & MASK_F8) == LEAD_4) len = 3'd4;
    else if ((b0 & MASK_FC) == LEAD_5) len = 3'd5;
    else if ((b0 & MASK_FE) == LEAD_6) len = 3'd6;
    else begin
      len     = 3'd0;
      lead_ok = 1'b0;
    end
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      cont_ok[k] = (bytes[k][7:6] == 2'b10);
      pl[k]      = bytes[k][5:0];
      need[k]    = (k != 0) && (LEN_W'(k) < len);
    end
  end

  assign avail_sat = (avail > AVAIL_MAX) ? AVAIL_MAX : avail;

  always_comb begin
    dec.ok  = lead_ok && (avail_sat != '0) && (avail_sat >= len) &&
              ((cont_ok | ~need) == 6'h3F);
    dec.len = len;
    unique case (len)
      3'd1:    dec.cp = RAW_W'(b0[6:0]);
      3'd2:    dec.cp = RAW_W'({b0[4:0], pl[1]});
      3'd3:    dec.cp = RAW_W'({b0[3:0], pl[1], pl[2]});
      3'd4:    dec.cp = RAW_W'({b0[2:0], pl[1], pl[2], pl[3]});
      3'd5:    dec.cp = RAW_W'({b0[1:0], pl[1], pl[2], pl[3], pl[4]});
      3'd6:    dec.cp = {b0[0], pl[1], pl[2], pl[3], pl[4], pl[5]};
      default: dec.cp = '0;
    endcase
  end
endmodule

@@ hw/rtl/extended_utf8_char_decoder.sv @@
// a beat accepted from char_in shows at char_out once it has passed the three
//   register stages
// throughput: one beat per cycle while char_out.ready is high, set by the three register stages
//   (decode, range checks, result select) advancing on downstream ready
// reset: rst, synchronous active high, empties the pipeline and loads the
//   registers with max 0x7FFFFFFF, trap 0xD800..0xDFFF, sentinel 0xFFFFFFFF
module extended_utf8_char_decoder (
  input  logic                        clk,
  input  logic                        rst,
  eu8_in_if.sink                      char_in,
  eu8_out_if.source                   char_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [eu8_pkg::ADDR_W-1:0]  paddr,
  input  logic [eu8_pkg::DATA_W-1:0]  pwdata,
  output logic [eu8_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import eu8_pkg::*;

  logic [CP_W-1:0] max_cp;
  logic [CP_W-1:0] trap_lo;
  logic [CP_W-1:0] trap_hi;
  logic [CP_W-1:0] sentinel;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_cp   <= MAX_CP_RESET;
      trap_lo  <= TRAP_LO_RESET;
      trap_hi  <= TRAP_HI_RESET;
      sentinel <= SENTINEL_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_MAX_CP:   max_cp   <= pwdata;
        REG_TRAP_LO:  trap_lo  <= pwdata;
        REG_TRAP_HI:  trap_hi  <= pwdata;
        REG_SENTINEL: sentinel <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MAX_CP:   prdata = max_cp;
      REG_TRAP_LO:  prdata = trap_lo;
      REG_TRAP_HI:  prdata = trap_hi;
      REG_SENTINEL: prdata = sentinel;
      default:      prdata = '0;
    endcase
  end

  // pipeline control
  logic v1, v2, v3;
  logic adv1, adv2, adv3;

  assign adv3 = !v3 || char_out.ready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign char_in.ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= char_in.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  // stage 1: structural decode
  dec_t dec_c;
  dec_t s1;

  eu8_decode u_decode (
    .bytes ({char_in.cont_byte_5, char_in.cont_byte_4, char_in.cont_byte_3,
             char_in.cont_byte_2, char_in.cont_byte_1, char_in.lead_byte}),
    .avail (char_in.bytes_available),
    .dec   (dec_c)
  );

  always_ff @(posedge clk) begin
    if (adv1) s1 <= dec_c;
  end

  // stage 2: limit, trap range, sentinel and overlong checks
  logic [CP_W-1:0]  cp1;
  logic             s2_ok;
  logic [LEN_W-1:0] s2_len;
  logic [CP_W-1:0]  s2_cp;
  logic             allowed;

  assign cp1 = CP_W'(s1.cp);
  assign allowed = (cp1 <= max_cp) && !((cp1 >= trap_lo) && (cp1 <= trap_hi)) &&
                   (cp1 != sentinel) && (shortest_len(cp1) == s1.len);

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_ok  <= s1.ok && allowed;
      s2_len <= s1.len;
      s2_cp  <= cp1;
    end
  end

  // stage 3: output register
  always_ff @(posedge clk) begin
    if (adv3) begin
      char_out.codepoint <= s2_ok ? s2_cp : sentinel;
      char_out.consumed  <= s2_ok ? s2_len : '0;
    end
  end

  assign char_out.valid = v3;
endmodule
